[hdl/tcprtt_pkg.sv]
`timescale 1ns / 1ps
package tcprtt_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int MSS_W    = 16;
  localparam int MINTO_W  = 16;
  localparam int THR_W    = 24;
  localparam int OWIN_W   = 24;
  localparam int RTO_W    = 18;
  localparam int SRTT_W   = 20;
  localparam int DEV_W    = 20;

  // internal widths
  localparam int MAG_W  = 18;  // |sample - srtt/8|
  localparam int TMP_W  = 21;  // dev + mag, srtt/4 + dev
  localparam int PROD_W = 32;  // mss * mss, and the quotient
  localparam int CNT_W  = 5;   // one step per quotient bit

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_TIMEOUT = 2'd0,
    REG_MSS         = 2'd1,
    REG_INIT_WINDOW = 2'd2
  } cfg_reg_t;

  localparam logic [MINTO_W-1:0] MIN_TIMEOUT_RST = 16'd50;
  localparam logic [MSS_W-1:0]   MSS_RST         = 16'd536;
  localparam logic [OWIN_W-1:0]  INIT_WINDOW_RST = 24'd536;

  localparam logic [SRTT_W-1:0] SRTT_MAX = '1;
  localparam logic [DEV_W-1:0]  DEV_MAX  = '1;
  localparam logic [RTO_W-1:0]  RTO_MAX  = '1;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DLT,
    S_DNEG,
    S_SRTT,
    S_DEV1,
    S_DEV2,
    S_RTO1,
    S_RTO2,
    S_WCMP,
    S_MUL,
    S_DIV,
    S_WADD,
    S_EMIT
  } seq_state_t;

endpackage

[hdl/tcprtt_if.sv]
`timescale 1ns / 1ps
interface tcprtt_in_if import tcprtt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] rtt_sample;
  logic                sample_valid;
  logic                retransmitting;
  logic [THR_W-1:0]    slow_start_threshold;

  modport source (
    output valid, rtt_sample, sample_valid, retransmitting, slow_start_threshold,
    input  ready
  );
  modport sink (
    input  valid, rtt_sample, sample_valid, retransmitting, slow_start_threshold,
    output ready
  );
endinterface

interface tcprtt_out_if import tcprtt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RTO_W-1:0]  timeout_ticks;
  logic [OWIN_W-1:0] window_bytes;
  logic [SRTT_W-1:0] smoothed_rtt_x8;
  logic [DEV_W-1:0]  rtt_deviation_x4;

  modport source (
    output valid, timeout_ticks, window_bytes, smoothed_rtt_x8, rtt_deviation_x4,
    input  ready
  );
  modport sink (
    input  valid, timeout_ticks, window_bytes, smoothed_rtt_x8, rtt_deviation_x4,
    output ready
  );
endinterface

[hdl/tcprtt_alu.sv]
`timescale 1ns / 1ps
// Shared add/subtract unit; top bit is carry out or borrow.
module tcprtt_alu import tcprtt_pkg::*; #(
  parameter int W = 33
) (
  input  alu_op_t      op,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W:0]   res
);

  assign res = (op == ALU_SUB) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});

endmodule

[hdl/tcp_rtt_and_cwnd_update_top.sv]
`timescale 1ns / 1ps
// RTT estimator and congestion window update, one acknowledgement per transfer.
// in_chan carries an ack event (sample, sample flag, retransmit flag, ssthresh);
// in_chan.ready is high only while the sequencer is idle. Each event gives
// exactly one result on out_chan: timeout, window, srtt*8 and deviation*4.
// The cfg port writes min timeout, MSS and initial window; the user must do
// so only while idle (the block does not enforce it). Before the first event
// a min timeout or initial window write also loads the live timeout/window.
// The shortest path is an event with no sample that stays in slow start; the
// longest has a sample and is in congestion avoidance. The longest is set by
// the mss*mss/cwnd division, one quotient bit per cycle through the single
// shared add/sub unit, which also carries the 6 or 7 estimator steps. A new
// event is taken only after the last one has reached the output register.
// Reset (synchronous, active low) clears srtt and deviation, loads the timeout
// with 50 and the window with 536, and restores register defaults.
// The result sits in an output register: a new event may be taken while it
// waits, but a stalled receiver holds the sequencer in its final step.
module tcp_rtt_and_cwnd_update_top import tcprtt_pkg::*; #(
  parameter int WINDOW_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tcprtt_in_if.sink             in_chan,
  tcprtt_out_if.source          out_chan
);

  // window held wide enough for both the limit and a loaded initial window
  localparam int CW_W  = (WINDOW_BITS > OWIN_W) ? WINDOW_BITS : OWIN_W;
  localparam int ALU_W = ((CW_W > PROD_W) ? CW_W : PROD_W) + 1;
  localparam logic [CW_W-1:0] WIN_LIM = CW_W'((64'd1 << WINDOW_BITS) - 64'd1);

  // control and architectural state
  seq_state_t           state_r, state_nxt;
  logic                 started_r, started_nxt;
  logic [MINTO_W-1:0]   min_to_r, min_to_nxt;
  logic [MSS_W-1:0]     mss_r, mss_nxt;
  logic [OWIN_W-1:0]    init_win_r, init_win_nxt;
  logic [SRTT_W-1:0]    srtt_r, srtt_nxt;
  logic [DEV_W-1:0]     dev_r, dev_nxt;
  logic [RTO_W-1:0]     rto_r, rto_nxt;
  logic [CW_W-1:0]      cwnd_r, cwnd_nxt;
  logic [CNT_W-1:0]     div_cnt_r, div_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // working registers
  logic [SAMPLE_W-1:0]  sample_r, sample_nxt;
  logic [THR_W-1:0]     thresh_r, thresh_nxt;
  logic [MAG_W-1:0]     mag_r, mag_nxt;
  logic                 neg_r, neg_nxt;
  logic [TMP_W-1:0]     tmp_r, tmp_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [CW_W-1:0]      rem_r, rem_nxt;

  // result register
  logic [RTO_W-1:0]     o_rto_r, o_rto_nxt;
  logic [OWIN_W-1:0]    o_win_r, o_win_nxt;
  logic [SRTT_W-1:0]    o_srtt_r, o_srtt_nxt;
  logic [DEV_W-1:0]     o_dev_r, o_dev_nxt;

  // shared unit
  alu_op_t              alu_op;
  logic [ALU_W-1:0]     alu_a, alu_b;
  logic [ALU_W:0]       alu_res;
  logic                 borrow;

  logic                 in_xfer;
  logic [PROD_W-1:0]    mss_sq;
  logic [TMP_W-2:0]     rto_half;

  tcprtt_alu #(.W(ALU_W)) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign borrow   = alu_res[ALU_W];
  assign in_xfer  = in_chan.valid & in_chan.ready;
  assign mss_sq   = PROD_W'(mss_r) * PROD_W'(mss_r);
  assign rto_half = tmp_r[TMP_W-1:1];

  assign in_chan.ready             = (state_r == S_IDLE);
  assign out_chan.valid            = out_valid_r;
  assign out_chan.timeout_ticks    = o_rto_r;
  assign out_chan.window_bytes     = o_win_r;
  assign out_chan.smoothed_rtt_x8  = o_srtt_r;
  assign out_chan.rtt_deviation_x4 = o_dev_r;

  always_comb begin
    state_nxt     = state_r;
    started_nxt   = started_r;
    min_to_nxt    = min_to_r;
    mss_nxt       = mss_r;
    init_win_nxt  = init_win_r;
    srtt_nxt      = srtt_r;
    dev_nxt       = dev_r;
    rto_nxt       = rto_r;
    cwnd_nxt      = cwnd_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r;
    sample_nxt    = sample_r;
    thresh_nxt    = thresh_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    tmp_nxt       = tmp_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    o_rto_nxt     = o_rto_r;
    o_win_nxt     = o_win_r;
    o_srtt_nxt    = o_srtt_r;
    o_dev_nxt     = o_dev_r;
    alu_op        = ALU_ADD;
    alu_a         = '0;
    alu_b         = '0;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    // config writes; before the first event they also seed live state
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_TIMEOUT: begin
          min_to_nxt = cfg_data[MINTO_W-1:0];
          if (!started_r) begin
            rto_nxt = RTO_W'(cfg_data[MINTO_W-1:0]);
          end
        end
        REG_MSS: begin
          mss_nxt = cfg_data[MSS_W-1:0];
        end
        REG_INIT_WINDOW: begin
          init_win_nxt = cfg_data[OWIN_W-1:0];
          if (!started_r) begin
            cwnd_nxt = CW_W'(cfg_data[OWIN_W-1:0]);
          end
        end
        default: begin
        end
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          started_nxt = 1'b1;
          sample_nxt  = in_chan.rtt_sample;
          thresh_nxt  = in_chan.slow_start_threshold;
          if (in_chan.sample_valid && !in_chan.retransmitting) begin
            // prime with the first sample
            if (srtt_r == '0) begin
              srtt_nxt = SRTT_W'({in_chan.rtt_sample, 3'b000});
            end
            state_nxt = S_DLT;
          end else begin
            state_nxt = S_WCMP;
          end
        end
      end
      S_DLT: begin
        alu_op = ALU_SUB;
        alu_a  = ALU_W'(sample_r);
        alu_b  = ALU_W'(srtt_r >> 3);
        if (borrow) begin
          state_nxt = S_DNEG;
        end else begin
          mag_nxt   = alu_res[MAG_W-1:0];
          neg_nxt   = 1'b0;
          state_nxt = S_SRTT;
        end
      end
      S_DNEG: begin
        alu_op    = ALU_SUB;
        alu_a     = ALU_W'(srtt_r >> 3);
        alu_b     = ALU_W'(sample_r);
        mag_nxt   = alu_res[MAG_W-1:0];
        neg_nxt   = 1'b1;
        state_nxt = S_SRTT;
      end
      S_SRTT: begin
        alu_op = neg_r ? ALU_SUB : ALU_ADD;
        alu_a  = ALU_W'(srtt_r);
        alu_b  = ALU_W'(mag_r);
        if (neg_r && borrow) begin
          srtt_nxt = '0;
        end else if (alu_res > (ALU_W+1)'(SRTT_MAX)) begin
          srtt_nxt = SRTT_MAX;
        end else begin
          srtt_nxt = alu_res[SRTT_W-1:0];
        end
        state_nxt = S_DEV1;
      end
      S_DEV1: begin
        alu_a     = ALU_W'(dev_r);
        alu_b     = ALU_W'(mag_r);
        tmp_nxt   = alu_res[TMP_W-1:0];
        state_nxt = S_DEV2;
      end
      S_DEV2: begin
        alu_op = ALU_SUB;
        alu_a  = ALU_W'(tmp_r);
        alu_b  = ALU_W'(dev_r >> 2);
        if (borrow) begin
          dev_nxt = '0;
        end else if (alu_res > (ALU_W+1)'(DEV_MAX)) begin
          dev_nxt = DEV_MAX;
        end else begin
          dev_nxt = alu_res[DEV_W-1:0];
        end
        state_nxt = S_RTO1;
      end
      S_RTO1: begin
        alu_a     = ALU_W'(srtt_r >> 2);
        alu_b     = ALU_W'(dev_r);
        tmp_nxt   = alu_res[TMP_W-1:0];
        state_nxt = S_RTO2;
      end
      S_RTO2: begin
        // clamp below by min timeout, then to field width
        alu_op = ALU_SUB;
        alu_a  = ALU_W'(rto_half);
        alu_b  = ALU_W'(min_to_r);
        if (borrow) begin
          rto_nxt = RTO_W'(min_to_r);
        end else if (rto_half > (TMP_W-1)'(RTO_MAX)) begin
          rto_nxt = RTO_MAX;
        end else begin
          rto_nxt = RTO_W'(rto_half);
        end
        state_nxt = S_WCMP;
      end
      S_WCMP: begin
        alu_op = ALU_SUB;
        alu_a  = ALU_W'(cwnd_r);
        alu_b  = ALU_W'(thresh_r);
        if (borrow) begin
          prod_nxt  = PROD_W'(mss_r);
          state_nxt = S_WADD;
        end else if (cwnd_r == '0) begin
          prod_nxt  = '0;
          state_nxt = S_WADD;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt    = mss_sq;
        rem_nxt     = '0;
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        // restoring division, quotient shifts in behind the dividend
        alu_op = ALU_SUB;
        alu_a  = ALU_W'({rem_r, prod_r[PROD_W-1]});
        alu_b  = ALU_W'(cwnd_r);
        if (borrow) begin
          rem_nxt = {rem_r[CW_W-2:0], prod_r[PROD_W-1]};
        end else begin
          rem_nxt = alu_res[CW_W-1:0];
        end
        prod_nxt    = {prod_r[PROD_W-2:0], ~borrow};
        div_cnt_nxt = div_cnt_r + CNT_W'(1);
        if (div_cnt_r == CNT_W'(PROD_W-1)) begin
          state_nxt = S_WADD;
        end
      end
      S_WADD: begin
        alu_a = ALU_W'(cwnd_r);
        alu_b = ALU_W'(prod_r);
        if (alu_res > (ALU_W+1)'(WIN_LIM)) begin
          cwnd_nxt = WIN_LIM;
        end else begin
          cwnd_nxt = alu_res[CW_W-1:0];
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          o_rto_nxt     = rto_r;
          o_win_nxt     = cwnd_r[OWIN_W-1:0];
          o_srtt_nxt    = srtt_r;
          o_dev_nxt     = dev_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      started_r   <= 1'b0;
      min_to_r    <= MIN_TIMEOUT_RST;
      mss_r       <= MSS_RST;
      init_win_r  <= INIT_WINDOW_RST;
      srtt_r      <= '0;
      dev_r       <= '0;
      rto_r       <= RTO_W'(MIN_TIMEOUT_RST);
      cwnd_r      <= CW_W'(INIT_WINDOW_RST);
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      min_to_r    <= min_to_nxt;
      mss_r       <= mss_nxt;
      init_win_r  <= init_win_nxt;
      srtt_r      <= srtt_nxt;
      dev_r       <= dev_nxt;
      rto_r       <= rto_nxt;
      cwnd_r      <= cwnd_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    thresh_r <= thresh_nxt;
    mag_r    <= mag_nxt;
    neg_r    <= neg_nxt;
    tmp_r    <= tmp_nxt;
    prod_r   <= prod_nxt;
    rem_r    <= rem_nxt;
    o_rto_r  <= o_rto_nxt;
    o_win_r  <= o_win_nxt;
    o_srtt_r <= o_srtt_nxt;
    o_dev_r  <= o_dev_nxt;
  end

`ifndef ASSERT_OFF
  // a result is only ever raised from the final step
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("out valid raised outside final step");

  // window update never leaves the window above its limit
  a_win_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WADD) |=> (cwnd_r <= WIN_LIM))
    else $error("window above limit after update");

  // division runs exactly one step per quotient bit
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_cnt_r == CNT_W'(PROD_W-1)) |=> (state_r == S_WADD))
    else $error("division did not finish after last quotient bit");

  // srtt moves only when priming on a transfer or in its update step
  a_srtt_src: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(srtt_r)) |->
      ($past(state_r == S_SRTT) || $past(in_chan.valid && in_chan.ready)))
    else $error("srtt changed outside its update");
`endif

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for the RTT estimator / congestion window block.
// Every ack transfer is fed through a local model of the estimator and the
// window; the result stream is compared field by field, in order.
module testbench;
  import tcprtt_pkg::*;

  localparam int WIN_BITS     = 24;
  localparam int DIRECTED_N   = 16;
  localparam int PHASE_N      = 5;
  localparam int IDLE_PERCENT = 18;
  localparam int SETTLE_CYC   = 64;   // a little over the worst-case latency

  // one ack event as presented on in_chan
  typedef struct packed {
    logic [SAMPLE_W-1:0] rtt_sample;
    logic                sample_valid;
    logic                retransmitting;
    logic [THR_W-1:0]    slow_start_threshold;
  } ack_t;

  // one estimator/window result as seen on out_chan
  typedef struct packed {
    logic [RTO_W-1:0]  timeout_ticks;
    logic [OWIN_W-1:0] window_bytes;
    logic [SRTT_W-1:0] smoothed_rtt_x8;
    logic [DEV_W-1:0]  rtt_deviation_x4;
  } estimate_t;

  // directed row: the ack, and a hand-worked result where one is given
  typedef struct packed {
    ack_t      ack;
    logic      typed;
    estimate_t want;
  } ack_row_t;

  // register setting for one stretch of random traffic
  typedef struct packed {
    logic [MINTO_W-1:0] min_to;
    logic [MSS_W-1:0]   mss;
    logic [OWIN_W-1:0]  init_win;
    logic [15:0]        acks;
  } reg_phase_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tcprtt_in_if  in_chan ();
  tcprtt_out_if out_chan ();

  tcp_rtt_and_cwnd_update_top #(
    .WINDOW_BITS (WIN_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  // 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the block: registers, then estimator and window state.
  logic [MINTO_W-1:0] shadow_min_to;
  logic [MSS_W-1:0]   shadow_mss;
  logic [OWIN_W-1:0]  shadow_init_win;
  logic [SRTT_W-1:0]  est_srtt;
  logic [DEV_W-1:0]   est_dev;
  logic [RTO_W-1:0]   est_rto;
  logic [OWIN_W-1:0]  est_cwnd;
  bit                 est_started;

  estimate_t awaited_estimates[$];
  int        mismatches;
  bit        no_idle;   // set for the stretch with no idling on either side

  // Register write as seen by the shadow. Until the first ack, a write of
  // the timeout floor or the initial window also loads the live value.
  function automatic void shadow_reg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_MIN_TIMEOUT: begin
        shadow_min_to = val[MINTO_W-1:0];
        if (!est_started) est_rto = RTO_W'(shadow_min_to);
      end
      REG_MSS: begin
        shadow_mss = val[MSS_W-1:0];
      end
      REG_INIT_WINDOW: begin
        shadow_init_win = val[OWIN_W-1:0];
        if (!est_started) est_cwnd = shadow_init_win;
      end
      default: ;
    endcase
  endfunction

  // Advances the shadow by one ack and returns the result it must produce.
  function automatic estimate_t next_estimate(ack_t a);
    longint lim;
    longint delta;
    longint mag;
    longint s;
    longint d;
    longint rto;
    longint inc;
    longint grown;
    lim = (longint'(1) << WIN_BITS) - 1;
    est_started = 1'b1;
    if (a.sample_valid && !a.retransmitting) begin
      // first non-zero sample primes srtt; a zero sample leaves it unprimed
      if (est_srtt == '0) est_srtt = SRTT_W'({a.rtt_sample, 3'b000});
      delta = longint'(a.rtt_sample) - longint'(est_srtt >> 3);
      s = longint'(est_srtt) + delta;
      if (s < 0) s = 0;
      if (s > longint'(SRTT_MAX)) s = longint'(SRTT_MAX);
      est_srtt = s[SRTT_W-1:0];
      mag = (delta < 0) ? -delta : delta;
      d = longint'(est_dev) + mag - longint'(est_dev >> 2);
      if (d < 0) d = 0;
      if (d > longint'(DEV_MAX)) d = longint'(DEV_MAX);
      est_dev = d[DEV_W-1:0];
      rto = ((longint'(est_srtt) >> 2) + longint'(est_dev)) >> 1;
      if (rto < longint'(shadow_min_to)) rto = longint'(shadow_min_to);
      if (rto > longint'(RTO_MAX)) rto = longint'(RTO_MAX);
      est_rto = rto[RTO_W-1:0];
    end
    // slow start adds an MSS, congestion avoidance mss^2/cwnd
    if (longint'(est_cwnd) < longint'(a.slow_start_threshold))
      inc = longint'(shadow_mss);
    else if (est_cwnd == '0)
      inc = 0;
    else
      inc = (longint'(shadow_mss) * longint'(shadow_mss)) / longint'(est_cwnd);
    grown = longint'(est_cwnd) + inc;
    if (grown > lim) grown = lim;
    est_cwnd = grown[OWIN_W-1:0];
    return '{est_rto, est_cwnd, est_srtt, est_dev};
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Random ack: mostly samples scattered round a base RTT, plus extremes,
  // and thresholds often placed right at the current window.
  function automatic ack_t random_ack(int base_rtt);
    ack_t   a;
    longint cw;
    longint t;
    int     pick;
    cw = longint'(est_cwnd);
    pick = $urandom_range(0, 19);
    case (pick)
      0:       a.rtt_sample = '0;
      1:       a.rtt_sample = '1;
      2, 3, 4: a.rtt_sample = SAMPLE_W'($urandom());
      5:       a.rtt_sample = SAMPLE_W'($urandom_range(1, 8));
      default: a.rtt_sample = SAMPLE_W'(base_rtt - base_rtt / 4 +
                                        $urandom_range(0, base_rtt / 2));
    endcase
    pick = $urandom_range(0, 9);
    a.sample_valid   = (pick != 0) && (pick != 1);
    a.retransmitting = (pick == 1) || (pick == 2);
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: t = longint'($urandom() & 32'hFF_FFFF);
      3, 4, 5: t = cw + longint'($urandom_range(0, 2)) - 1;
      6:       t = 0;
      7:       t = (longint'(1) << THR_W) - 1;
      default: t = cw * 2;
    endcase
    if (t < 0) t = 0;
    if (t > (longint'(1) << THR_W) - 1) t = (longint'(1) << THR_W) - 1;
    a.slow_start_threshold = t[THR_W-1:0];
    return a;
  endfunction

  // Presents one ack from a falling edge, with random idle cycles first,
  // and holds it until the transfer. Hand-worked rows override the shadow's
  // answer but still step it.
  task automatic send_ack(ack_t a, logic typed, estimate_t want);
    estimate_t predicted;
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid                <= 1'b1;
    in_chan.rtt_sample           <= a.rtt_sample;
    in_chan.sample_valid         <= a.sample_valid;
    in_chan.retransmitting       <= a.retransmitting;
    in_chan.slow_start_threshold <= a.slow_start_threshold;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    predicted = next_estimate(a);
    awaited_estimates.push_back(typed ? want : predicted);
  endtask

  // Stop sending, let every outstanding result come back, then wait for the
  // sequencer to show ready again so a register write lands while idle.
  task automatic drain;
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (awaited_estimates.size() != 0) @(posedge clk);
    do @(posedge clk); while (in_chan.ready !== 1'b1);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    shadow_reg_write(idx, val);
  endtask

  task automatic end_writes;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: ready drops at random except in the no-idle stretch.
  always @(negedge clk) begin
    out_chan.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Every result transfer is matched with the oldest expectation.
  always @(posedge clk) begin
    estimate_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (awaited_estimates.size() == 0) begin
        $error("result transfer with no ack outstanding");
        mismatches++;
      end else begin
        want = awaited_estimates.pop_front();
        check_field("timeout_ticks", want.timeout_ticks, out_chan.timeout_ticks);
        check_field("window_bytes", want.window_bytes, out_chan.window_bytes);
        check_field("smoothed_rtt_x8", want.smoothed_rtt_x8, out_chan.smoothed_rtt_x8);
        check_field("rtt_deviation_x4", want.rtt_deviation_x4,
                    out_chan.rtt_deviation_x4);
      end
    end
  end

  // Watchdog, far beyond the slowest legal run (~1200 acks, stalls included).
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    ack_row_t   directed_acks [DIRECTED_N];
    reg_phase_t reg_phases [PHASE_N];
    int         base_rtt;

    // Directed rows, starting from min timeout 0, MSS 1460 and a zero
    // window loaded before the first ack. The opening rows are worked by
    // hand: zero window at a zero threshold, ignored sample while
    // retransmitting, a zero sample that does not prime, growth from a zero
    // window, then priming with 100 ticks.
    directed_acks = '{
      '{'{16'd0,      1'b0, 1'b0, 24'd0},       1'b1, '{18'd0,   24'd0,    20'd0,   20'd0}},
      '{'{16'hFFFF,   1'b1, 1'b1, 24'd0},       1'b1, '{18'd0,   24'd0,    20'd0,   20'd0}},
      '{'{16'd0,      1'b1, 1'b0, 24'd0},       1'b1, '{18'd0,   24'd0,    20'd0,   20'd0}},
      '{'{16'd0,      1'b0, 1'b0, 24'd1},       1'b1, '{18'd0,   24'd1460, 20'd0,   20'd0}},
      '{'{16'd100,    1'b1, 1'b0, 24'hFFFFFF},  1'b1, '{18'd100, 24'd2920, 20'd800, 20'd0}},
      '{'{16'hFFFF,   1'b1, 1'b0, 24'd0},       1'b0, '0},
      '{'{16'd0,      1'b1, 1'b0, 24'd0},       1'b0, '0},
      '{'{16'd0,      1'b1, 1'b0, 24'd0},       1'b0, '0},
      '{'{16'hFFFF,   1'b0, 1'b1, 24'hFFFFFF},  1'b0, '0},
      '{'{16'hFFFF,   1'b1, 1'b1, 24'd0},       1'b0, '0},
      '{'{16'd1,      1'b1, 1'b0, 24'hFFFFFF},  1'b0, '0},
      '{'{16'h8000,   1'b1, 1'b0, 24'h800000},  1'b0, '0},
      '{'{16'h7FFF,   1'b1, 1'b0, 24'd0},       1'b0, '0},
      '{'{16'hFFFF,   1'b1, 1'b0, 24'hFFFFFF},  1'b0, '0},
      '{'{16'hAAAA,   1'b1, 1'b0, 24'h555555},  1'b0, '0},
      '{'{16'h5555,   1'b1, 1'b0, 24'hAAAAAA},  1'b0, '0}
    };

    // Random stretches: timeout floor at both ends, MSS of 1 and of zero
    // (no growth at all), and MSS at its maximum last, as that drives the
    // window into saturation. Initial window writes after the first ack must
    // not disturb the live window.
    reg_phases = '{
      '{16'hFFFF, 16'd1,     24'hFFFFFF, 16'd150},
      '{16'd50,   16'd536,   24'd536,    16'd300},
      '{16'd200,  16'd0,     24'd0,      16'd100},
      '{16'd1,    16'd1460,  24'h123456, 16'd300},
      '{16'd0,    16'hFFFF,  24'd4096,   16'd300}
    };

    // shadow starts at reset defaults
    shadow_min_to   = MIN_TIMEOUT_RST;
    shadow_mss      = MSS_RST;
    shadow_init_win = INIT_WINDOW_RST;
    est_srtt        = '0;
    est_dev         = '0;
    est_rto         = RTO_W'(MIN_TIMEOUT_RST);
    est_cwnd        = INIT_WINDOW_RST;
    est_started     = 1'b0;
    mismatches      = 0;
    no_idle         = 1'b0;

    // all block inputs known from time zero
    rst_n                        = 1'b0;
    cfg_we                       = 1'b0;
    cfg_index                    = REG_MIN_TIMEOUT;
    cfg_data                     = '0;
    in_chan.valid                = 1'b0;
    in_chan.rtt_sample           = '0;
    in_chan.sample_valid         = 1'b0;
    in_chan.retransmitting       = 1'b0;
    in_chan.slow_start_threshold = '0;
    out_chan.ready               = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (in_chan.ready !== 1'b1);

    // Before the first ack these writes also load the live timeout and
    // window, so the run starts from a zero window and a zero floor.
    write_reg(REG_MIN_TIMEOUT, 24'd0);
    write_reg(REG_MSS, 24'd1460);
    write_reg(REG_INIT_WINDOW, 24'd0);
    end_writes();

    foreach (directed_acks[i])
      send_ack(directed_acks[i].ack, directed_acks[i].typed, directed_acks[i].want);

    foreach (reg_phases[p]) begin
      drain();
      write_reg(REG_MIN_TIMEOUT, CFG_DATA_W'(reg_phases[p].min_to));
      write_reg(REG_MSS, CFG_DATA_W'(reg_phases[p].mss));
      write_reg(REG_INIT_WINDOW, reg_phases[p].init_win);
      end_writes();
      base_rtt = $urandom_range(1, 5000);
      // second stretch opens with back-to-back traffic on both sides
      no_idle = (p == 1);
      for (int k = 0; k < int'(reg_phases[p].acks); k++) begin
        if (p == 1 && k == int'(reg_phases[p].acks) / 2) begin
          // hold the sender until every result is back, mid-stream
          no_idle = 1'b0;
          drain();
        end
        send_ack(random_ack(base_rtt), 1'b0, '0);
      end
    end

    drain();
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
